@@ rtl/core/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the keyed slot table
// Holds the table size, derived widths, beat types and the codes used by
// the controller and the top level.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_W    = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FREE_W   = 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWAP_RD,
        S_SWAP_WR,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] plate_key;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [FREE_W-1:0] free_slots;
    } rsp_beat_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
    } mem_req_t;

endpackage

@@ rtl/core/kst_key_ram.sv @@
// ----------------------------------------------------------------------------
// kst_key_ram: key storage for the keyed slot table
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read request.
// ----------------------------------------------------------------------------
module kst_key_ram (
    input  logic                       clk,
    input  kst_pkg::mem_req_t          mem,
    output logic [kst_pkg::KEY_W-1:0]  rd_data
);

    logic [kst_pkg::KEY_W-1:0] key_mem [kst_pkg::CAPACITY];
    logic [kst_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem.wr_en)
        begin
            key_mem[mem.wr_addr] <= mem.wr_data;
        end
        if (mem.rd_en)
        begin
            rd_data_reg <= key_mem[mem.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/kst_ctrl.sv @@
// ----------------------------------------------------------------------------
// kst_ctrl: sequencer for the keyed slot table
// Appends keys on insert, scans the key memory one entry per cycle on
// remove, and moves the last held key into the matching entry.
// ----------------------------------------------------------------------------
module kst_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  kst_pkg::req_beat_t         req,
    output logic                       res_valid,
    input  logic                       res_stall,
    output kst_pkg::rsp_beat_t         res,
    output kst_pkg::mem_req_t          mem,
    input  logic [kst_pkg::KEY_W-1:0]  rd_data
);

    kst_pkg::ctrl_state_t              state_reg, state_next;
    logic [kst_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [kst_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic [kst_pkg::ADDR_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                              cmp_valid_reg, cmp_valid_next;
    logic [kst_pkg::ADDR_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [kst_pkg::KEY_W-1:0]         key_reg, key_next;
    kst_pkg::status_t                  status_reg, status_next;

    logic [kst_pkg::CNT_W-1:0]         last_idx;
    logic [kst_pkg::CNT_W-1:0]         free_cnt;
    logic                              hit;

    assign last_idx = count_reg - kst_pkg::CNT_W'(1);
    assign free_cnt = kst_pkg::CNT_W'(kst_pkg::CAPACITY) - count_reg;
    assign hit      = cmp_valid_reg && (rd_data == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kst_pkg::S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_idx_next   = hit_idx_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        mem            = '0;
        req_stall      = 1'b1;
        res_valid      = 1'b0;

        unique case (state_reg)
            kst_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    key_next = req.plate_key;
                    if (req.action == kst_pkg::ACT_INSERT)
                    begin
                        if (count_reg >= kst_pkg::CNT_W'(kst_pkg::CAPACITY))
                        begin
                            status_next = kst_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem.wr_en   = 1'b1;
                            mem.wr_addr = count_reg[kst_pkg::ADDR_W-1:0];
                            mem.wr_data = req.plate_key;
                            count_next  = count_reg + kst_pkg::CNT_W'(1);
                            status_next = kst_pkg::ST_DONE;
                        end
                        state_next = kst_pkg::S_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = kst_pkg::ST_EMPTY;
                        state_next  = kst_pkg::S_FINISH;
                    end
                    else
                    begin
                        idx_next       = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = kst_pkg::S_SCAN;
                    end
                end
            end

            kst_pkg::S_SCAN:
            begin
                priority if (hit)
                begin
                    hit_idx_next   = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = kst_pkg::S_SWAP_RD;
                end
                else if (idx_reg < count_reg)
                begin
                    mem.rd_en      = 1'b1;
                    mem.rd_addr    = idx_reg[kst_pkg::ADDR_W-1:0];
                    cmp_idx_next   = idx_reg[kst_pkg::ADDR_W-1:0];
                    cmp_valid_next = 1'b1;
                    idx_next       = idx_reg + kst_pkg::CNT_W'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    status_next = kst_pkg::ST_MISSING;
                    state_next  = kst_pkg::S_FINISH;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end

            kst_pkg::S_SWAP_RD:
            begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = last_idx[kst_pkg::ADDR_W-1:0];
                state_next  = kst_pkg::S_SWAP_WR;
            end

            kst_pkg::S_SWAP_WR:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = hit_idx_reg;
                mem.wr_data = rd_data;
                count_next  = last_idx;
                status_next = kst_pkg::ST_DONE;
                state_next  = kst_pkg::S_FINISH;
            end

            kst_pkg::S_FINISH:
            begin
                res_valid = 1'b1;
                if (!res_stall)
                begin
                    state_next = kst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kst_pkg::S_IDLE;
            end
        endcase
    end

    assign res.status     = status_reg;
    assign res.free_slots = kst_pkg::FREE_W'(free_cnt);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kst_pkg::CNT_W'(kst_pkg::CAPACITY))
        else $error("occupancy count exceeds table size");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kst_pkg::S_SCAN |-> !mem.wr_en)
        else $error("key memory written during a scan");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kst_pkg::S_IDLE && req_valid && req.action == kst_pkg::ACT_INSERT
         && count_reg < kst_pkg::CNT_W'(kst_pkg::CAPACITY))
        |=> count_reg == $past(count_reg) + kst_pkg::CNT_W'(1))
        else $error("insert did not advance the count");

    a_swap_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kst_pkg::S_SWAP_WR |=> count_reg == $past(last_idx))
        else $error("remove did not reduce the count");

endmodule

@@ rtl/core/keyed_slot_table.sv @@
// ----------------------------------------------------------------------------
// keyed_slot_table: unordered key table with swap-remove
// An insert beat appends its key unless the table is full; a remove beat
// deletes the first stored copy of its key by moving the last entry into
// its place. Every request beat yields exactly one response beat with a
// status code and the number of free entries after the operation.
//
// Requests enter on req/req_valid/req_stall, responses leave on
// rsp/rsp_valid/rsp_stall; a beat moves when valid is high and stall low.
// One request is handled at a time. An insert or a remove on an empty table
// goes from acceptance straight to the finish state, which loads the
// response register. A remove reads the key memory one entry per cycle from
// entry 0, so its duration grows with the index of the match, or with the
// count when no key matches, as the key memory has a single read port.
// Reset empties the table at once; no clearing pass is needed. The
// response register lets the next request be accepted while a response
// waits; a stalled receiver holds the response and blocks the next one.
// ----------------------------------------------------------------------------
module keyed_slot_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  kst_pkg::req_beat_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output kst_pkg::rsp_beat_t  rsp
);

    kst_pkg::mem_req_t          mem;
    logic [kst_pkg::KEY_W-1:0]  rd_data;
    logic                       res_valid;
    logic                       res_stall;
    kst_pkg::rsp_beat_t         res;

    logic                       rsp_valid_reg, rsp_valid_next;
    kst_pkg::rsp_beat_t         rsp_reg;
    logic                       rsp_load;

    kst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .mem       (mem),
        .rd_data   (rd_data)
    );

    kst_key_ram u_key_ram (
        .clk     (clk),
        .mem     (mem),
        .rd_data (rd_data)
    );

    assign rsp_load       = !rsp_valid_reg || !rsp_stall;
    assign res_stall      = !rsp_load;
    assign rsp_valid_next = rsp_load ? res_valid : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
